// ----- hw/rtl/fcci_pkg.sv -----
// ----------------------------------------------------------------------------
// fcci_pkg
// Shared types, constants and the byte-wide CRC-16/CCITT-FALSE update for
// the frame counter and CRC trailer inserter.
// ----------------------------------------------------------------------------
package fcci_pkg;

  localparam int MAX_FRAME_LENGTH = 1024;
  localparam int MIN_FRAME_LENGTH = 7;

  localparam int BYTE_W = 8;
  localparam int CRC_W  = 16;
  localparam int CNT_W  = 16;
  localparam int LEN_W  = 11;
  localparam int POS_W  = $clog2(MAX_FRAME_LENGTH);
  localparam int EFF_W  = $clog2(MAX_FRAME_LENGTH + 1);

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [0:0] REG_FRAME_LENGTH = 1'b0;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(21);
  localparam logic [CRC_W-1:0] CRC_INIT  = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY  = 16'h1021;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } beat_t;

  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/fcci_in_stage.sv -----
// ----------------------------------------------------------------------------
// fcci_in_stage
// Input register: holds one accepted beat until the processing stage takes it.
// ----------------------------------------------------------------------------
module fcci_in_stage (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [fcci_pkg::BYTE_W-1:0] frame_byte,
  input  logic                       advance,
  output fcci_pkg::beat_t            beat
);
  import fcci_pkg::*;

  logic load;

  assign load     = !beat.valid || advance;
  assign in_stall = beat.valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat.valid <= 1'b0;
    end else if (load) begin
      beat.valid <= in_valid;
    end
    if (load && in_valid) begin
      beat.data <= frame_byte;
    end
  end

endmodule

// ----- hw/rtl/fcci_proc.sv -----
// ----------------------------------------------------------------------------
// fcci_proc
// Frame state, counter and CRC substitution, and the result register.
// ----------------------------------------------------------------------------
module fcci_proc (
  input  logic                        clk,
  input  logic                        rst,
  input  fcci_pkg::beat_t             beat,
  input  logic [fcci_pkg::EFF_W-1:0]  eff_len,
  output logic                        advance,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [fcci_pkg::BYTE_W-1:0] out_byte,
  output logic                        last_of_frame
);
  import fcci_pkg::*;

  logic [CNT_W-1:0]  frame_counter;
  logic [POS_W-1:0]  byte_position;
  logic [CRC_W-1:0]  running_crc;

  logic [CNT_W-1:0]  frame_counter_next;
  logic [POS_W-1:0]  byte_position_next;
  logic [CRC_W-1:0]  running_crc_next;
  logic [BYTE_W-1:0] out_byte_next;
  logic              last_next;
  logic [EFF_W-1:0]  pos;
  logic              take;

  assign advance = !out_valid || !out_stall;
  assign take    = advance && beat.valid;
  assign pos     = EFF_W'(byte_position);

  always_comb begin
    last_next          = (pos >= eff_len - EFF_W'(1));
    frame_counter_next = frame_counter;
    running_crc_next   = running_crc;
    out_byte_next      = beat.data;
    if (byte_position == '0) begin
      frame_counter_next = frame_counter + CNT_W'(1);
    end
    if (!last_next) begin
      if (pos == EFF_W'(2)) begin
        out_byte_next = frame_counter_next[CNT_W-1:BYTE_W];
      end else if (pos == EFF_W'(3)) begin
        out_byte_next = frame_counter_next[BYTE_W-1:0];
      end
      if (pos == eff_len - EFF_W'(3)) begin
        out_byte_next = running_crc[CRC_W-1:BYTE_W];
      end else if (pos == eff_len - EFF_W'(2)) begin
        out_byte_next = running_crc[BYTE_W-1:0];
      end else if (pos >= EFF_W'(1) && pos <= eff_len - EFF_W'(4)) begin
        running_crc_next = crc_byte(running_crc, out_byte_next);
      end
    end
    if (last_next) begin
      byte_position_next = '0;
      running_crc_next   = CRC_INIT;
    end else begin
      byte_position_next = byte_position + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_counter <= '0;
      byte_position <= '0;
      running_crc   <= CRC_INIT;
      out_valid     <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= beat.valid;
      end
      if (take) begin
        frame_counter <= frame_counter_next;
        byte_position <= byte_position_next;
        running_crc   <= running_crc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_byte      <= out_byte_next;
      last_of_frame <= last_next;
    end
  end

endmodule

// ----- hw/rtl/frame_counter_crc_inserter_unit.sv -----
// ----------------------------------------------------------------------------
// frame_counter_crc_inserter_unit
// Frame byte stream pass-through with frame counter and CRC trailer insertion.
//
// Bytes of an outgoing frame enter on the input channel (in_valid, in_stall,
// frame_byte), one per beat, and leave on the output channel (out_valid,
// out_stall, out_byte, last_of_frame), one result beat per input beat.
// Bytes 2 and 3 carry the incremented 16-bit frame counter, and bytes
// length-3 and length-2 carry the CRC-16/CCITT-FALSE over bytes 1 through
// length-4. last_of_frame marks the final byte of each frame.
// An input beat passes through an input register and a result register, with
// the counter and CRC update between them.
// Throughput is one beat per cycle while out_stall is low; the byte-wide CRC update sets the path.
// While out_stall holds a result, one more input beat is taken into the input
// register before in_stall rises. frame_length (APB offset 0) is saturated to
// 7..1024; the user must write it only while the channels are idle, which the
// block does not enforce. Reset clears both stages, the frame counter, the
// byte position and the CRC, and sets frame_length to 21.
// ----------------------------------------------------------------------------
module frame_counter_crc_inserter_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fcci_pkg::ADDR_W-1:0] paddr,
  input  logic [fcci_pkg::DATA_W-1:0] pwdata,
  output logic [fcci_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [fcci_pkg::BYTE_W-1:0] frame_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [fcci_pkg::BYTE_W-1:0] out_byte,
  output logic                        last_of_frame
);
  import fcci_pkg::*;

  logic [LEN_W-1:0] frame_length;
  logic [EFF_W-1:0] eff_len;
  logic             advance;
  logic             sel_len;
  beat_t            beat;

  assign pready  = 1'b1;
  assign sel_len = (paddr[ADDR_W-1:2] == REG_FRAME_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length <= LEN_RESET;
    end else if (psel && penable && pwrite && pready && sel_len) begin
      frame_length <= pwdata[LEN_W-1:0];
    end
  end

  always_comb begin
    if (sel_len) begin
      prdata = DATA_W'(frame_length);
    end else begin
      prdata = '0;
    end
  end

  always_comb begin
    if (32'(frame_length) < 32'(MIN_FRAME_LENGTH)) begin
      eff_len = EFF_W'(MIN_FRAME_LENGTH);
    end else if (32'(frame_length) > 32'(MAX_FRAME_LENGTH)) begin
      eff_len = EFF_W'(MAX_FRAME_LENGTH);
    end else begin
      eff_len = EFF_W'(frame_length);
    end
  end

  fcci_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .frame_byte (frame_byte),
    .advance    (advance),
    .beat       (beat)
  );

  fcci_proc u_proc (
    .clk           (clk),
    .rst           (rst),
    .beat          (beat),
    .eff_len       (eff_len),
    .advance       (advance),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .last_of_frame (last_of_frame)
  );

endmodule

// ----- bench/fcci_stream_checker.sv -----
// ----------------------------------------------------------------------------
// fcci_stream_checker
// Watches the configuration port and both byte channels of the frame counter
// and CRC trailer inserter. Every accepted input beat is run through a local
// model of the frame position, counter and CRC state. The predicted beat is
// queued, and each accepted output beat is compared with the oldest entry.
// Reports the failure count, the number of beats still awaited and run
// statistics to the testbench top.
// ----------------------------------------------------------------------------
module fcci_stream_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [fcci_pkg::ADDR_W-1:0] paddr,
  input  logic [fcci_pkg::DATA_W-1:0] pwdata,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [fcci_pkg::BYTE_W-1:0] frame_byte,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [fcci_pkg::BYTE_W-1:0] out_byte,
  input  logic                        last_of_frame,
  output int                          outstanding,
  output int                          error_count,
  output int                          beats_checked,
  output int                          frames_seen
);

  localparam logic [fcci_pkg::ADDR_W-1:0] FRAME_LENGTH_ADDR =
    fcci_pkg::ADDR_W'(4 * fcci_pkg::REG_FRAME_LENGTH);
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [fcci_pkg::BYTE_W-1:0] data;
    logic                        last;
  } tx_beat_t;

  tx_beat_t                     expected_beats[$];
  logic [fcci_pkg::LEN_W-1:0]   frame_len;
  logic [fcci_pkg::CNT_W-1:0]   frame_count;
  logic [fcci_pkg::CRC_W-1:0]   crc_acc;
  int                           byte_pos;
  int                           mismatches;
  int                           checked;
  int                           frames;

  function automatic logic [fcci_pkg::CRC_W-1:0] crc16_step(
    input logic [fcci_pkg::CRC_W-1:0]  crc,
    input logic [fcci_pkg::BYTE_W-1:0] data
  );
    logic [fcci_pkg::CRC_W-1:0] r;
    logic                       fb;
    r = crc;
    for (int i = fcci_pkg::BYTE_W - 1; i >= 0; i--) begin
      fb = r[fcci_pkg::CRC_W-1] ^ data[i];
      r  = {r[fcci_pkg::CRC_W-2:0], 1'b0};
      if (fb) begin
        r = r ^ fcci_pkg::CRC_POLY;
      end
    end
    return r;
  endfunction

  task automatic predict_beat(input logic [fcci_pkg::BYTE_W-1:0] raw);
    int                          len;
    logic [fcci_pkg::BYTE_W-1:0] o;
    logic                        fin;
    len = int'(frame_len);
    if (len < fcci_pkg::MIN_FRAME_LENGTH) begin
      len = fcci_pkg::MIN_FRAME_LENGTH;
    end
    if (len > fcci_pkg::MAX_FRAME_LENGTH) begin
      len = fcci_pkg::MAX_FRAME_LENGTH;
    end
    fin = (byte_pos >= len - 1);
    if (byte_pos == 0) begin
      frame_count = frame_count + 1'b1;
    end
    o = raw;
    if (!fin) begin
      if (byte_pos == 2) begin
        o = frame_count[15:8];
      end else if (byte_pos == 3) begin
        o = frame_count[7:0];
      end
      if (byte_pos == len - 3) begin
        o = crc_acc[15:8];
      end else if (byte_pos == len - 2) begin
        o = crc_acc[7:0];
      end else if (byte_pos >= 1 && byte_pos <= len - 4) begin
        crc_acc = crc16_step(crc_acc, o);
      end
    end
    if (fin) begin
      byte_pos = 0;
      crc_acc  = fcci_pkg::CRC_INIT;
    end else begin
      byte_pos = byte_pos + 1;
    end
    expected_beats.push_back('{data: o, last: fin});
  endtask

  always @(posedge clk) begin
    tx_beat_t want;
    if (rst) begin
      frame_len   = fcci_pkg::LEN_RESET;
      frame_count = '0;
      crc_acc     = fcci_pkg::CRC_INIT;
      byte_pos    = 0;
      mismatches  = 0;
      checked     = 0;
      frames      = 0;
      expected_beats.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == FRAME_LENGTH_ADDR) begin
        frame_len = pwdata[fcci_pkg::LEN_W-1:0];
      end
      if (in_valid && !in_stall) begin
        predict_beat(frame_byte);
      end
      if (out_valid && !out_stall) begin
        checked++;
        if (last_of_frame) begin
          frames++;
        end
        if (expected_beats.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("unexpected output beat %0d: byte %02h last %0b",
                     checked, out_byte, last_of_frame);
          end
        end else begin
          want = expected_beats.pop_front();
          if (want.data !== out_byte || want.last !== last_of_frame) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("mismatch at beat %0d: expected byte %02h last %0b, got byte %02h last %0b",
                       checked, want.data, want.last, out_byte, last_of_frame);
            end
          end
        end
      end
    end
    outstanding   <= expected_beats.size();
    error_count   <= mismatches;
    beats_checked <= checked;
    frames_seen   <= frames;
  end

endmodule

// ----- bench/tb_frame_counter_crc_inserter_unit.sv -----
// ----------------------------------------------------------------------------
// tb_frame_counter_crc_inserter_unit
// Drives frames of bytes into the frame counter and CRC trailer inserter
// under several frame lengths (below the minimum, small, and saturated at the
// maximum), changes the length mid-frame, and mixes sender gaps and receiver
// stalls. Checking is done by fcci_stream_checker; this module only makes
// stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb_frame_counter_crc_inserter_unit;

  localparam logic [fcci_pkg::ADDR_W-1:0] FRAME_LENGTH_ADDR =
    fcci_pkg::ADDR_W'(4 * fcci_pkg::REG_FRAME_LENGTH);
  localparam logic [fcci_pkg::ADDR_W-1:0] UNMAPPED_ADDR =
    fcci_pkg::ADDR_W'(4 * (fcci_pkg::REG_FRAME_LENGTH + 1));
  localparam int PHASES = 12;

  logic                        clk;
  logic                        rst;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [fcci_pkg::ADDR_W-1:0] paddr;
  logic [fcci_pkg::DATA_W-1:0] pwdata;
  logic [fcci_pkg::DATA_W-1:0] prdata;
  logic                        pready;
  logic                        in_valid;
  logic                        in_stall;
  logic [fcci_pkg::BYTE_W-1:0] frame_byte;
  logic                        out_valid;
  logic                        out_stall;
  logic [fcci_pkg::BYTE_W-1:0] out_byte;
  logic                        last_of_frame;

  int outstanding;
  int error_count;
  int beats_checked;
  int frames_seen;
  int idle_pct  = 0;
  int stall_pct = 0;
  int items_sent = 0;

  frame_counter_crc_inserter_unit dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .frame_byte   (frame_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .last_of_frame(last_of_frame)
  );

  fcci_stream_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .frame_byte   (frame_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .last_of_frame(last_of_frame),
    .outstanding  (outstanding),
    .error_count  (error_count),
    .beats_checked(beats_checked),
    .frames_seen  (frames_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 200000);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_byte(input logic [fcci_pkg::BYTE_W-1:0] b);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    frame_byte <= b;
    in_valid   <= 1'b1;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic apb_write(input logic [fcci_pkg::ADDR_W-1:0] addr,
                           input logic [fcci_pkg::DATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [fcci_pkg::BYTE_W-1:0] random_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return fcci_pkg::BYTE_W'($urandom_range(255));
    endcase
  endfunction

  initial begin
    int len_val;
    int beat_count;
    rst        = 1'b1;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_valid   = 1'b0;
    frame_byte = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset length, alternating extremes
    for (int i = 0; i < 21; i++) begin
      send_byte(i[0] ? 8'hFF : 8'h00);
    end
    hold_until_drained();
    apb_write(UNMAPPED_ADDR, 32'd9);
    apb_write(FRAME_LENGTH_ADDR, 32'd0);
    repeat (7) send_byte(8'hFF);
    hold_until_drained();

    // shorten the frame past the current position
    apb_write(FRAME_LENGTH_ADDR, 32'd40);
    repeat (10) send_byte(8'hA5);
    hold_until_drained();
    apb_write(FRAME_LENGTH_ADDR, 32'd8);
    repeat (3) send_byte(8'h5A);
    hold_until_drained();

    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 77; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 77; end
        default: begin idle_pct = 8; stall_pct = 8; end
      endcase
      beat_count = 70;
      if (p == 5) begin
        len_val = 2047;
      end else if (p == 9) begin
        len_val    = 1025;
        beat_count = 40;
      end else if (p == 10) begin
        len_val = $urandom_range(0, 6);
      end else begin
        len_val = $urandom_range(7, 40);
      end
      apb_write(FRAME_LENGTH_ADDR, ($urandom & 32'hFFFF_F800) | 32'(len_val));
      for (int i = 0; i < beat_count; i++) begin
        send_byte(random_byte());
        if (p == 1 && i == beat_count / 2) begin
          hold_until_drained();
        end
      end
      hold_until_drained();
    end

    idle_pct  = 0;
    stall_pct = 0;
    hold_until_drained();
    repeat (8) @(posedge clk);
    $display("run: %0d input beats, %0d output beats compared, %0d frames closed",
             items_sent, beats_checked, frames_seen);
    $display("lengths below minimum through 1024 ceiling, mid-frame shortening, four gap mixes");
    if (error_count == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
